// ----- sv/hs1d_pkg.sv -----
package hs1d_pkg;

    // Fixed widths of the data path and of the result fields
    localparam int VAL_W     = 32;
    localparam int COEFF_W   = 15;
    localparam int POINTS_W  = 7;
    localparam int STEPS_W   = 16;
    localparam int INDEX_W   = 6;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // Default row length
    localparam int MAX_POINTS_DEF = 64;

    // Coefficient limit (0.5 in Q0.15) and the Q0.15 fraction bits
    localparam logic [COEFF_W-1:0] COEFF_MAX = 15'd16384;
    localparam int                 FRAC_W    = 15;
    localparam logic [POINTS_W-1:0] MIN_POINTS = 7'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_GRID_POINTS = 2'd0;
    localparam logic [1:0] REG_TIME_STEPS  = 2'd1;
    localparam logic [1:0] REG_DIFF_COEFF  = 2'd2;

    // Effective settings handed from the register file to the control
    typedef struct packed {
        logic [POINTS_W-1:0] points;
        logic [STEPS_W-1:0]  steps;
        logic [COEFF_W-1:0]  coeff;
    } t_cfg;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_cell_ctl;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

endpackage

// ----- sv/hs1d_cell.sv -----
module hs1d_cell (
    input  logic                          i_clk,
    input  hs1d_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_interior,
    input  logic [hs1d_pkg::VAL_W-1:0]    i_load_val,
    input  logic [hs1d_pkg::COEFF_W-1:0]  i_coeff,
    input  logic [hs1d_pkg::VAL_W-1:0]    i_left,
    input  logic [hs1d_pkg::VAL_W-1:0]    i_right,
    output logic [hs1d_pkg::VAL_W-1:0]    o_value
);
    import hs1d_pkg::*;

    localparam int DIFF_W = VAL_W + 2;
    localparam int PROD_W = DIFF_W + COEFF_W + 1;
    localparam int SUM_W  = VAL_W + 4;

    logic [VAL_W-1:0]         r_value;
    logic [VAL_W-1:0]         n_value;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0]  w_sum;

    // new = m + s*(l + r - 2m) / 2^15, floored; equal to the exact
    // three-term weighted sum truncated by 15 bits
    always_comb begin
        w_diff = signed'({2'b00, i_left}) + signed'({2'b00, i_right})
               - signed'({1'b0, r_value, 1'b0});
        w_prod = w_diff * signed'({1'b0, i_coeff});
        w_sum  = signed'({{(SUM_W-VAL_W){1'b0}}, r_value})
               + SUM_W'(w_prod >>> FRAC_W);
    end

    // load, update or shift toward index zero
    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_load_val;
        end else if (i_ctl.step) begin
            n_value = i_interior ? w_sum[VAL_W-1:0] : '0;
        end else if (i_ctl.shift) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- sv/hs1d_regs.sv -----
module hs1d_regs #(
    parameter int MAX_POINTS = hs1d_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hs1d_pkg::APB_AW-1:0]  paddr,
    input  logic [hs1d_pkg::APB_DW-1:0]  pwdata,
    output logic [hs1d_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output hs1d_pkg::t_cfg               o_cfg
);
    import hs1d_pkg::*;

    localparam logic [POINTS_W-1:0] MAX_N = POINTS_W'(MAX_POINTS);

    logic [POINTS_W-1:0] r_grid_points;
    logic [STEPS_W-1:0]  r_time_steps;
    logic [COEFF_W-1:0]  r_diff_coeff;
    logic                w_wr;
    logic [1:0]          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_points <= 7'd64;
            r_time_steps  <= 16'd1;
            r_diff_coeff  <= 15'd8192;
        end else if (w_wr) begin
            case (w_idx)
                REG_GRID_POINTS: r_grid_points <= pwdata[POINTS_W-1:0];
                REG_TIME_STEPS:  r_time_steps  <= pwdata[STEPS_W-1:0];
                REG_DIFF_COEFF:  r_diff_coeff  <= pwdata[COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_GRID_POINTS: prdata = APB_DW'(r_grid_points);
            REG_TIME_STEPS:  prdata = APB_DW'(r_time_steps);
            REG_DIFF_COEFF:  prdata = APB_DW'(r_diff_coeff);
            default:         prdata = '0;
        endcase
    end

    // clamp the grid points and the coefficient to the supported ranges
    always_comb begin
        if (r_grid_points < MIN_POINTS) begin
            o_cfg.points = MIN_POINTS;
        end else if (r_grid_points > MAX_N) begin
            o_cfg.points = MAX_N;
        end else begin
            o_cfg.points = r_grid_points;
        end
        o_cfg.steps = r_time_steps;
        o_cfg.coeff = (r_diff_coeff > COEFF_MAX) ? COEFF_MAX : r_diff_coeff;
    end

endmodule

// ----- sv/heat_stencil_1d_solver.sv -----
// Channel   Direction  Handshake          Word
// input     in         i_valid / o_stall  i_source_heat
// output    out        o_valid / i_stall  o_point_index, o_temperature, o_last
// config    in         APB                grid_points, time_steps, diffusion_coeff
//
// For each item the cell chain first runs its update phase and makes
// time_steps - 1 updates (a time_steps of zero counts as one); each cell
// updates once per cycle in this phase. The control then leaves the update
// phase and emits one point per cycle while the output does not stall. The
// row is shifted out of cell zero into an output register.
// Reset is synchronous, active low. Output stalls hold the chain shift.
// A new word is taken once the last point sits in the output register.
module heat_stencil_1d_solver #(
    parameter int MAX_POINTS = hs1d_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hs1d_pkg::VAL_W-1:0]    i_source_heat,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hs1d_pkg::INDEX_W-1:0]  o_point_index,
    output logic [hs1d_pkg::VAL_W-1:0]    o_temperature,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hs1d_pkg::APB_AW-1:0]   paddr,
    input  logic [hs1d_pkg::APB_DW-1:0]   pwdata,
    output logic [hs1d_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import hs1d_pkg::*;

    t_cfg                w_cfg;
    t_cell_ctl           w_ctl;
    t_state              r_state;
    t_state              n_state;
    logic [STEPS_W-1:0]  r_steps_left;
    logic [STEPS_W-1:0]  n_steps_left;
    logic [INDEX_W-1:0]  r_emit_idx;
    logic [INDEX_W-1:0]  n_emit_idx;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [INDEX_W-1:0]  r_out_idx;
    logic [VAL_W-1:0]    r_out_temp;
    logic                r_out_last;
    logic                w_accept;
    logic                w_emit;
    logic                w_emit_last;
    logic [POINTS_W-1:0] w_center;
    logic [VAL_W-1:0]    w_val [MAX_POINTS];

    hs1d_regs #(
        .MAX_POINTS (MAX_POINTS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid & ~o_stall;
    assign w_emit      = (r_state == S_EMIT) & (~r_out_valid | ~i_stall);
    assign w_emit_last = ({1'b0, r_emit_idx} == (w_cfg.points - 7'd1));
    assign w_center    = w_cfg.points >> 1;

    // chain commands
    always_comb begin
        w_ctl.load  = w_accept;
        w_ctl.step  = (r_state == S_RUN) & (r_steps_left != '0);
        w_ctl.shift = w_emit;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_steps_left = r_steps_left;
        n_emit_idx   = r_emit_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_steps_left = (w_cfg.steps == '0) ? '0 : w_cfg.steps - 16'd1;
                    n_emit_idx   = '0;
                    n_state      = S_RUN;
                end
            end
            S_RUN: begin
                if (r_steps_left == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_steps_left = r_steps_left - 16'd1;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_emit_idx = r_emit_idx + 6'd1;
                    if (w_emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (~i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_steps_left <= '0;
            r_emit_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_steps_left <= n_steps_left;
            r_emit_idx   <= n_emit_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_idx  <= r_emit_idx;
            r_out_temp <= w_val[0];
            r_out_last <= w_emit_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_point_index = r_out_idx;
    assign o_temperature = r_out_temp;
    assign o_last        = r_out_last;

    // row of cells, MAX_POINTS of them, one per possible grid point
    for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        logic             w_interior;
        logic [VAL_W-1:0] w_load_val;

        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[gi-1];
        end
        if (gi == MAX_POINTS - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[gi+1];
        end

        assign w_interior = (gi != 0) && (POINTS_W'(gi) < (w_cfg.points - 7'd1));
        assign w_load_val = (POINTS_W'(gi) == w_center) ? i_source_heat : '0;

        hs1d_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_interior (w_interior),
            .i_load_val (w_load_val),
            .i_coeff    (w_cfg.coeff),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_value    (w_val[gi])
        );
    end

endmodule
